[rtl/ome_pkg.sv]
// shared types and constants for the ordered member list engine
`default_nettype none

package ome_pkg;

    // field widths
    localparam int KEY_W    = 32;
    localparam int NAME_W   = 64;
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // default list capacity and the largest number of entries one dump shows
    localparam int CAPACITY_DEF = 16;
    localparam int DUMP_LIMIT   = 16;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ADD_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ADD_BLAST = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DEL_FRONT = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DEL_BACK  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DEL_KEY   = 3'd5;
    localparam logic [REQ_W-1:0] REQ_DUMP      = 3'd6;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOKEY = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUMP  = 3'd4;

    // one stored entry
    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [KEY_W-1:0]  key;
    } t_entry;

    // one result item
    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key;
        logic [NAME_W-1:0]   name;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } t_result;

    // memory port control
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage

`default_nettype wire

[rtl/ordered_member_list_engine.sv]
// ordered member list engine: stream ports, output register, sequencer and storage
//
//  channel  dir  tdata                                        tuser          tlast
//  s_*      in   member_key, member_name                      req_type       -
//  m_*      out  out_key, out_name, entry_count, zero pad     status         last_result
//
// Each request is taken in the idle cycle and then holds the input until its results
// are handed to the output register; output stalls hold the sequencer. Add before
// last reads the last entry, writes it one place up, then writes the new entry in
// the old last place; it only appends when the list holds fewer than two entries.
// Delete by key compares entries in turn, then moves each later one down by a read
// and a write. A dump hands out one entry per free output slot. The store has one
// memory port. Reset is synchronous and empties the list; entries are not cleared.
`default_nettype none

module ordered_member_list_engine
    import ome_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [95:0]  i_s_tdata,   // member_key, member_name
    input  wire logic [2:0]   i_s_tuser,   // req_type
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [103:0]      o_m_tdata,   // out_key, out_name, entry_count, zero pad
    output logic [2:0]        o_m_tuser,   // status
    output logic              o_m_tlast    // last_result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    t_result       w_res;
    t_result       r_out;
    logic          r_out_valid;
    logic          w_slot_free;
    t_mem_ctl      w_mem_ctl;
    logic [AW-1:0] w_mem_addr;
    t_entry        w_mem_wdata;
    t_entry        w_mem_rdata;

    // output slot frees when empty or taken this cycle
    assign w_slot_free = !r_out_valid || i_m_tready;

    ome_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_req       (i_s_tuser),
        .i_key       (i_s_tdata[KEY_W-1:0]),
        .i_name      (i_s_tdata[KEY_W+NAME_W-1:KEY_W]),
        .i_slot_free (w_slot_free),
        .o_res       (w_res),
        .o_mem_ctl   (w_mem_ctl),
        .o_mem_addr  (w_mem_addr),
        .o_mem_wdata (w_mem_wdata),
        .i_mem_rdata (w_mem_rdata)
    );

    ome_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            r_out <= w_res;
        end
    end

    // master side transaction fields
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out.count, r_out.name, r_out.key};
    assign o_m_tuser  = r_out.status;
    assign o_m_tlast  = r_out.last;

endmodule

`default_nettype wire

[rtl/ome_mem.sv]
// entry storage: one port, write or registered read
`default_nettype none

module ome_mem
    import ome_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int AW    = $clog2(CAPACITY_DEF)
) (
    input  wire logic          i_clk,
    input  wire t_mem_ctl      i_ctl,
    input  wire logic [AW-1:0] i_addr,
    input  wire t_entry        i_wdata,
    output t_entry             o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/ome_seq.sv]
// request sequencer with circular head pointer and shared address unit
`default_nettype none

module ome_seq
    import ome_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY_DEF)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [REQ_W-1:0]  i_req,
    input  wire logic [KEY_W-1:0]  i_key,
    input  wire logic [NAME_W-1:0] i_name,
    input  wire logic              i_slot_free,
    output t_result                o_res,
    output t_mem_ctl               o_mem_ctl,
    output logic [AW-1:0]          o_mem_addr,
    output t_entry                 o_mem_wdata,
    input  wire t_entry            i_mem_rdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW:0]   SUM_CAP  = (CW+1)'(CAPACITY);
    localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);
    localparam logic [CW-1:0] IDX_PREV = CW'(CAPACITY - 1);
    localparam logic [CW-1:0] ONE      = CW'(1);

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EMIT     = 3'd1;
    localparam logic [2:0] S_BL_W1    = 3'd2;
    localparam logic [2:0] S_BL_W2    = 3'd3;
    localparam logic [2:0] S_SRCH_CMP = 3'd4;
    localparam logic [2:0] S_SHF_RD   = 3'd5;
    localparam logic [2:0] S_SHF_WR   = 3'd6;
    localparam logic [2:0] S_DMP_OUT  = 3'd7;

    logic [2:0]          r_state, n_state;
    logic [AW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [NAME_W-1:0]   r_name, n_name;

    logic [CW-1:0] w_lidx;
    logic [CW:0]   w_sum;
    logic [AW-1:0] w_phys;
    logic [CW:0]   w_idx_inc;
    logic [CW:0]   w_cnt_ext;
    logic          w_full;
    logic          w_empty;
    logic          w_accept;
    logic          w_dump_last;

    assign w_full      = (r_count == CNT_FULL);
    assign w_empty     = (r_count == '0);
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_idx_inc   = (CW+1)'(r_idx) + (CW+1)'(1);
    assign w_cnt_ext   = (CW+1)'(r_count);
    assign w_dump_last = (w_idx_inc == w_cnt_ext) || (int'(w_idx_inc) == DUMP_LIMIT);

    // shared address unit: logical position to physical slot, one wrap step
    always_comb begin
        w_sum  = (CW+1)'(r_head) + (CW+1)'(w_lidx);
        w_phys = (w_sum >= SUM_CAP) ? AW'(w_sum - SUM_CAP) : AW'(w_sum);
    end

    assign o_mem_addr = w_phys;

    // next state, memory control and result
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_idx       = r_idx;
        n_status    = r_status;
        n_key       = r_key;
        n_name      = r_name;
        w_lidx      = r_idx;
        o_mem_ctl   = '0;
        o_mem_wdata = i_mem_rdata;
        o_res       = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_key    = i_key;
                    n_name   = i_name;
                    n_status = ST_DONE;
                    n_state  = S_EMIT;
                    n_idx    = '0;
                    case (i_req)
                        REQ_ADD_FRONT: begin
                            w_lidx = IDX_PREV;
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_mem_ctl.we = 1'b1;
                                o_mem_wdata  = '{name: i_name, key: i_key};
                                n_head       = w_phys;
                                n_count      = r_count + ONE;
                            end
                        end
                        REQ_ADD_BACK: begin
                            w_lidx = r_count;
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_mem_ctl.we = 1'b1;
                                o_mem_wdata  = '{name: i_name, key: i_key};
                                n_count      = r_count + ONE;
                            end
                        end
                        REQ_ADD_BLAST: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else if (r_count < CW'(2)) begin
                                // short list: plain append
                                w_lidx       = r_count;
                                o_mem_ctl.we = 1'b1;
                                o_mem_wdata  = '{name: i_name, key: i_key};
                                n_count      = r_count + ONE;
                            end else begin
                                // fetch the last entry, it moves up one place
                                w_lidx       = r_count - ONE;
                                o_mem_ctl.re = 1'b1;
                                n_state      = S_BL_W1;
                            end
                        end
                        REQ_DEL_FRONT: begin
                            w_lidx = ONE;
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_head  = w_phys;
                                n_count = r_count - ONE;
                            end
                        end
                        REQ_DEL_BACK: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - ONE;
                            end
                        end
                        REQ_DEL_KEY: begin
                            w_lidx = '0;
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                o_mem_ctl.re = 1'b1;
                                n_state      = S_SRCH_CMP;
                            end
                        end
                        REQ_DUMP: begin
                            w_lidx = '0;
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                o_mem_ctl.re = 1'b1;
                                n_state      = S_DMP_OUT;
                            end
                        end
                        default: begin
                            n_status = ST_DONE;
                        end
                    endcase
                end
            end

            // old last entry goes one place up
            S_BL_W1: begin
                w_lidx       = r_count;
                o_mem_ctl.we = 1'b1;
                o_mem_wdata  = i_mem_rdata;
                n_state      = S_BL_W2;
            end

            // new entry takes the old last place
            S_BL_W2: begin
                w_lidx       = r_count - ONE;
                o_mem_ctl.we = 1'b1;
                o_mem_wdata  = '{name: r_name, key: r_key};
                n_count      = r_count + ONE;
                n_status     = ST_DONE;
                n_state      = S_EMIT;
            end

            // key compare, one entry per cycle
            S_SRCH_CMP: begin
                if (i_mem_rdata.key == r_key) begin
                    if (w_idx_inc == w_cnt_ext) begin
                        n_count  = r_count - ONE;
                        n_status = ST_DONE;
                        n_state  = S_EMIT;
                    end else begin
                        n_state = S_SHF_RD;
                    end
                end else if (w_idx_inc == w_cnt_ext) begin
                    n_status = ST_NOKEY;
                    n_state  = S_EMIT;
                end else begin
                    w_lidx       = CW'(w_idx_inc);
                    o_mem_ctl.re = 1'b1;
                    n_idx        = CW'(w_idx_inc);
                end
            end

            // close the gap: read the entry above
            S_SHF_RD: begin
                w_lidx       = CW'(w_idx_inc);
                o_mem_ctl.re = 1'b1;
                n_state      = S_SHF_WR;
            end

            // close the gap: write it one place down
            S_SHF_WR: begin
                w_lidx       = r_idx;
                o_mem_ctl.we = 1'b1;
                o_mem_wdata  = i_mem_rdata;
                n_idx        = CW'(w_idx_inc);
                if (w_idx_inc + (CW+1)'(1) == w_cnt_ext) begin
                    n_count  = r_count - ONE;
                    n_status = ST_DONE;
                    n_state  = S_EMIT;
                end else begin
                    n_state = S_SHF_RD;
                end
            end

            // one dump entry per free output slot
            S_DMP_OUT: begin
                if (i_slot_free) begin
                    o_res.valid  = 1'b1;
                    o_res.status = ST_DUMP;
                    o_res.key    = i_mem_rdata.key;
                    o_res.name   = i_mem_rdata.name;
                    o_res.count  = COUNT_W'(r_count);
                    o_res.last   = w_dump_last;
                    if (w_dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        w_lidx       = CW'(w_idx_inc);
                        o_mem_ctl.re = 1'b1;
                        n_idx        = CW'(w_idx_inc);
                    end
                end
            end

            // single closing result
            S_EMIT: begin
                if (i_slot_free) begin
                    o_res.valid  = 1'b1;
                    o_res.status = r_status;
                    o_res.count  = COUNT_W'(r_count);
                    o_res.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_status <= n_status;
        r_key    <= n_key;
        r_name   <= n_name;
    end

endmodule

`default_nettype wire

[bench/tb_top.sv]
// self-checking stream bench for the ordered member list engine
`timescale 1ns / 1ps

module tb_top;
    import ome_pkg::*;

    localparam int RANDOM_ITEMS = 320;
    localparam int QUIET_TAIL   = 50;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 200;
    localparam int MAX_PRINTS   = 40;
    localparam int NAME_LO      = KEY_W;
    localparam int COUNT_LO     = KEY_W + NAME_W;

    // code 7 is not a request; the block answers it with a plain done
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [KEY_W-1:0]  key;
        logic [NAME_W-1:0] name;
    } t_request;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key;
        logic [NAME_W-1:0]   name;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } t_answer;

    logic         i_clk    = 1'b0;
    logic         i_rst_n  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata  = '0;    // member_key, member_name
    logic [2:0]   s_tuser  = '0;    // req_type
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;          // out_key, out_name, entry_count, zero pad
    logic [2:0]   m_tuser;          // status
    logic         m_tlast;          // last_result

    // shadow copy of the list
    logic [KEY_W-1:0]  list_keys  [CAPACITY_DEF];
    logic [NAME_W-1:0] list_names [CAPACITY_DEF];
    int                list_len = 0;

    t_request request_queue [$];
    t_answer  due_answers [$];
    t_request cur_request = '0;

    int   taken          = 0;
    int   total_requests = 0;
    int   errors         = 0;
    int   prints         = 0;
    int   send_gap       = 0;
    int   recv_stall     = 0;
    logic calm           = 1'b0;
    logic hold_off       = 1'b0;

    ordered_member_list_engine #(
        .CAPACITY (CAPACITY_DEF)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (prints < MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        prints++;
    endtask

    function automatic logic idling_ok();
        return !calm && (taken + QUIET_TAIL < total_requests);
    endfunction

    function automatic t_request make_request(input logic [REQ_W-1:0] req,
                                              input logic [KEY_W-1:0] key,
                                              input logic [NAME_W-1:0] name);
        t_request rq;
        rq.req  = req;
        rq.key  = key;
        rq.name = name;
        return rq;
    endfunction

    task automatic push_answer(input logic [STATUS_W-1:0] st, input logic [KEY_W-1:0] key,
                               input logic [NAME_W-1:0] name, input logic lst);
        t_answer ans;
        ans.status = st;
        ans.key    = key;
        ans.name   = name;
        ans.count  = list_len[COUNT_W-1:0];
        ans.last   = lst;
        due_answers.push_back(ans);
    endtask

    // open a slot at pos and store the entry there, unless the list is full
    task automatic place_entry(input int pos, input t_request rq,
                               output logic [STATUS_W-1:0] st);
        int i;
        if (list_len >= CAPACITY_DEF) begin
            st = ST_FULL;
            return;
        end
        for (i = list_len; i > pos; i--) begin
            list_keys[i]  = list_keys[i-1];
            list_names[i] = list_names[i-1];
        end
        list_keys[pos]  = rq.key;
        list_names[pos] = rq.name;
        list_len++;
        st = ST_DONE;
    endtask

    // close the slot at pos
    task automatic drop_entry(input int pos, output logic [STATUS_W-1:0] st);
        int i;
        if (list_len == 0) begin
            st = ST_EMPTY;
            return;
        end
        for (i = pos; i < list_len - 1; i++) begin
            list_keys[i]  = list_keys[i+1];
            list_names[i] = list_names[i+1];
        end
        list_len--;
        st = ST_DONE;
    endtask

    // apply one request to the shadow list and queue the answers it causes
    task automatic update_member_list(input t_request rq);
        logic [STATUS_W-1:0] st;
        int n;
        int hit;
        int i;
        st = ST_DONE;
        case (rq.req)
            REQ_ADD_FRONT: place_entry(0, rq, st);
            REQ_ADD_BACK:  place_entry(list_len, rq, st);
            REQ_ADD_BLAST: place_entry(list_len < 2 ? list_len : list_len - 1, rq, st);
            REQ_DEL_FRONT: drop_entry(0, st);
            REQ_DEL_BACK:  drop_entry(list_len - 1, st);
            REQ_DEL_KEY: begin
                hit = -1;
                for (i = 0; i < list_len && hit < 0; i++) begin
                    if (list_keys[i] == rq.key) hit = i;
                end
                if (list_len == 0) st = ST_EMPTY;
                else if (hit < 0) st = ST_NOKEY;
                else drop_entry(hit, st);
            end
            REQ_DUMP: begin
                n = list_len < DUMP_LIMIT ? list_len : DUMP_LIMIT;
                if (n == 0) push_answer(ST_EMPTY, '0, '0, 1'b1);
                for (i = 0; i < n; i++) begin
                    push_answer(ST_DUMP, list_keys[i], list_names[i], i == n - 1);
                end
                return;
            end
            default: st = ST_DONE;
        endcase
        push_answer(st, '0, '0, 1'b1);
    endtask

    // request side: one transaction at a time from the queue, random gaps between
    always @(posedge i_clk) begin : request_driver
        logic offer;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                update_member_list(cur_request);
                taken++;
                offer = 1'b0;
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (request_queue.size() > 0) begin
                    cur_request = request_queue.pop_front();
                    offer = 1'b1;
                    if (idling_ok() && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 9);
                end
            end
            s_tvalid <= offer;
            s_tdata  <= {cur_request.name, cur_request.key};
            s_tuser  <= cur_request.req;
        end
    end

    // result side: check each transaction against the oldest answer due
    always @(posedge i_clk) begin : result_monitor
        t_answer want;
        logic ready;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_answers.size() == 0) begin
                    report_mismatch($sformatf("result with none due, status %0d", m_tuser));
                end else begin
                    want = due_answers.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d", m_tuser, want.status));
                    if (m_tdata[KEY_W-1:0] !== want.key)
                        report_mismatch($sformatf("out_key %h, want %h",
                                                  m_tdata[KEY_W-1:0], want.key));
                    if (m_tdata[NAME_LO +: NAME_W] !== want.name)
                        report_mismatch($sformatf("out_name %h, want %h",
                                                  m_tdata[NAME_LO +: NAME_W], want.name));
                    if (m_tdata[COUNT_LO +: COUNT_W] !== want.count)
                        report_mismatch($sformatf("entry_count %0d, want %0d",
                                                  m_tdata[COUNT_LO +: COUNT_W], want.count));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last_result %b, want %b", m_tlast, want.last));
                end
            end
            ready = 1'b1;
            if (recv_stall > 0) begin
                recv_stall--;
                ready = 1'b0;
            end else if (idling_ok() && $urandom_range(0, 3) == 0) begin
                recv_stall = $urandom_range(0, 8);
                ready = 1'b0;
            end
            m_tready <= ready && !hold_off;
        end
    end

    // stretches with no idling on either side
    initial begin : calm_toggle
        forever begin
            repeat ($urandom_range(40, 160)) @(posedge i_clk);
            calm <= ~calm;
        end
    end

    // one long receiver hold-off so the block backs up into its input
    initial begin : output_hold
        while (taken < HOLD_AT) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : run_limit
        #5_000_000;
        $display("ordered_member_list_engine regression: fail");
        $finish;
    end

    initial begin : stimulus
        t_request         rq;
        logic [KEY_W-1:0] key_pool [8];
        logic [REQ_W-1:0] insert_kinds [3];
        logic [REQ_W-1:0] delete_kinds [3];
        int               produced;
        int               insert_pct;
        int               pick;
        int               i;

        insert_kinds = '{REQ_ADD_FRONT, REQ_ADD_BACK, REQ_ADD_BLAST};
        delete_kinds = '{REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_KEY};

        // empty list: dump and every delete are no-ops, code 7 is ignored
        request_queue.push_back(make_request(REQ_DUMP, '0, '0));
        request_queue.push_back(make_request(REQ_DEL_FRONT, '0, '0));
        request_queue.push_back(make_request(REQ_DEL_BACK, '0, '0));
        request_queue.push_back(make_request(REQ_DEL_KEY, '0, '0));
        request_queue.push_back(make_request(REQ_UNUSED, '1, '1));
        // add before last with zero and one entries appends
        request_queue.push_back(make_request(REQ_ADD_BLAST, '0, '0));
        request_queue.push_back(make_request(REQ_ADD_BLAST, '1, '1));
        // fill to capacity with a mix of inserts, last front key is 0x100c
        for (i = 0; i < CAPACITY_DEF - 2; i++) begin
            request_queue.push_back(make_request(insert_kinds[i % 3], 32'h1000 + i,
                                                 {$urandom, $urandom}));
        end
        // full list rejects every insert, then a full dump
        request_queue.push_back(make_request(REQ_ADD_FRONT, 32'h55, '1));
        request_queue.push_back(make_request(REQ_ADD_BACK, 32'h66, '1));
        request_queue.push_back(make_request(REQ_ADD_BLAST, 32'h77, '1));
        request_queue.push_back(make_request(REQ_DUMP, '0, '0));
        // key miss, key hit on the first entry, plain deletes
        request_queue.push_back(make_request(REQ_DEL_KEY, 32'h0bad_0000, '0));
        request_queue.push_back(make_request(REQ_DEL_KEY, 32'h0000_100c, '0));
        request_queue.push_back(make_request(REQ_DEL_FRONT, '0, '0));
        request_queue.push_back(make_request(REQ_DEL_BACK, '0, '0));

        // small key pool so deletes by key often hit and keys repeat
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (i = 2; i < 8; i++) key_pool[i] = $urandom;

        // random segments that lean toward growing, shrinking or neither
        produced = 0;
        while (produced < RANDOM_ITEMS) begin
            case ($urandom_range(0, 2))
                0:       insert_pct = 70;
                1:       insert_pct = 20;
                default: insert_pct = 45;
            endcase
            repeat ($urandom_range(12, 40)) begin
                pick    = $urandom_range(0, 99);
                rq.key  = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 7)] : $urandom;
                rq.name = {$urandom, $urandom};
                if (pick < 2) rq.req = REQ_UNUSED;
                else if (pick < 12) rq.req = REQ_DUMP;
                else if (pick < 12 + insert_pct) rq.req = insert_kinds[$urandom_range(0, 2)];
                else rq.req = delete_kinds[$urandom_range(0, 2)];
                request_queue.push_back(rq);
                if (rq.req != REQ_UNUSED) produced++;
            end
        end
        total_requests = request_queue.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (taken < total_requests || due_answers.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("ordered_member_list_engine regression: pass");
        end else begin
            $display("ordered_member_list_engine regression: fail");
        end
        $finish;
    end

endmodule
